// ----- rtl/qnco_pkg.sv -----
// Shared types, constants and arithmetic helpers of the quadrature NCO table generator.
`default_nettype none

package qnco_pkg;

   // Default widths of the phase accumulator and the sample counter.
   localparam int QNCO_PHASE_BITS = 32;
   localparam int QNCO_COUNT_BITS = 16;

   // Fixed-point widths: working values, saturated magnitudes and full products.
   localparam int VAL_W  = 42;
   localparam int MAG_W  = 40;
   localparam int HALF_W = 20;
   localparam int PROD_W = 80;

   // Configuration port geometry and register indexes.
   localparam int   CSR_ADDR_W           = 3;
   localparam logic CSR_IDX_PHASE_STEP   = 1'b0;
   localparam logic CSR_IDX_TABLE_LENGTH = 1'b1;

   // Arithmetic constants.
   localparam logic [MAG_W-1:0]        PI_Q30    = 40'd3373259426;
   localparam logic [MAG_W-1:0]        MAG_MAX   = {MAG_W{1'b1}};
   localparam logic signed [VAL_W-1:0] ONE_Q30   = 42'sd1073741824;
   localparam logic [PROD_W-1:0]       ROUND_Q30 = 80'h2000_0000;
   localparam logic [PROD_W-1:0]       ROUND_Q31 = 80'h4000_0000;
   localparam int                      ROUND_Q14 = 32768;
   localparam int                      Q14_LIMIT = 16384;

   // Horner term indexes at which each polynomial closes with the constant one.
   localparam logic [2:0] COS_LAST = 3'd6;
   localparam logic [2:0] SIN_LAST = 3'd4;

   // Polynomial coefficients in Q2.30, highest degree first.
   localparam logic signed [VAL_W-1:0] COS_COEF [0:6] = '{
      42'sd0, 42'sd2, -42'sd296, 42'sd26631, -42'sd1491308, 42'sd44739244,
      -42'sd536870912
   };
   localparam logic signed [VAL_W-1:0] SIN_COEF [0:4] = '{
      -42'sd27, 42'sd2959, -42'sd213044, 42'sd8947849, -42'sd178956971
   };

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LO,
      ST_HI,
      ST_WB,
      ST_DONE
   } state_type;

   // Products evaluated on the shared multiplier.
   typedef enum logic [2:0] {
      OP_X,
      OP_Z,
      OP_COS,
      OP_SIN,
      OP_SINX
   } op_type;

   // Phase of one multiply: low half, high half, round and write back.
   typedef enum logic [1:0] {
      MPH_NONE,
      MPH_LO,
      MPH_HI,
      MPH_WB
   } mul_phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          load_item;
      logic          out_load;
      mul_phase_type phase;
      op_type        op;
      logic [2:0]    term;
   } qnco_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_ready;
   } qnco_status_type;

   // Magnitude of a working value, saturated to the multiplier operand range.
   function automatic logic [MAG_W-1:0] mag_sat(input logic signed [VAL_W-1:0] v);
      logic [VAL_W-1:0] m;
      m = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
      return (m > VAL_W'(MAG_MAX)) ? MAG_MAX : m[MAG_W-1:0];
   endfunction

   // Constant added after a product: next coefficient, or one to close a polynomial.
   function automatic logic signed [VAL_W-1:0] coef_addend(input op_type op,
                                                          input logic [2:0] term);
      logic signed [VAL_W-1:0] c;
      case (op)
         OP_COS:  c = (term < COS_LAST) ? COS_COEF[3'(term + 3'd1)] : ONE_Q30;
         OP_SIN:  c = (term < SIN_LAST) ? SIN_COEF[3'(term + 3'd1)] : ONE_Q30;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Q2.30 to Q2.14 with rounding half away from zero, saturation and optional negation.
   function automatic logic [15:0] to_q14(input logic signed [VAL_W-1:0] v,
                                          input logic negate);
      logic [VAL_W-1:0]  m;
      logic [VAL_W:0]    sum;
      logic [VAL_W-16:0] q;
      logic [15:0]       qc;
      logic [15:0]       r;
      m   = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
      sum = {1'b0, m} + (VAL_W+1)'(ROUND_Q14);
      q   = sum[VAL_W:16];
      qc  = (q > (VAL_W-15)'(Q14_LIMIT)) ? 16'(Q14_LIMIT) : 16'(q);
      r   = v[VAL_W-1] ? (16'd0 - qc) : qc;
      return negate ? (16'd0 - r) : r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/qnco_ctrl.sv -----
// Controller state machine that sequences the shared multiplier through each sample.
`default_nettype none

module qnco_ctrl
   import qnco_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire qnco_status_type status,
   output qnco_cmd_type         cmd
);

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   logic [2:0] term_ff, term_in;

   // State, operation and term registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_X;
         term_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         term_ff  <= term_in;
      end
   end

   // Next state: each product passes through a low, a high and a write-back state.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      term_in  = term_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LO;
               op_in    = OP_X;
               term_in  = 3'd0;
            end
         end
         ST_LO: state_in = ST_HI;
         ST_HI: state_in = ST_WB;
         ST_WB: begin
            state_in = ST_LO;
            case (op_ff)
               OP_X: begin
                  op_in   = OP_Z;
                  term_in = 3'd0;
               end
               OP_Z: begin
                  op_in   = OP_COS;
                  term_in = 3'd0;
               end
               OP_COS: begin
                  if (term_ff == COS_LAST) begin
                     op_in   = OP_SIN;
                     term_in = 3'd0;
                  end else begin
                     term_in = term_ff + 3'd1;
                  end
               end
               OP_SIN: begin
                  if (term_ff == SIN_LAST) begin
                     op_in   = OP_SINX;
                     term_in = 3'd0;
                  end else begin
                     term_in = term_ff + 3'd1;
                  end
               end
               OP_SINX: state_in = ST_DONE;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DONE: begin
            if (status.out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake and datapath commands.
   always_comb begin
      req_tready    = 1'b0;
      cmd.load_item = 1'b0;
      cmd.out_load  = 1'b0;
      cmd.phase     = MPH_NONE;
      cmd.op        = op_ff;
      cmd.term      = term_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_LO:   cmd.phase = MPH_LO;
         ST_HI:   cmd.phase = MPH_HI;
         ST_WB:   cmd.phase = MPH_WB;
         ST_DONE: cmd.out_load = status.out_ready;
         default: cmd.phase = MPH_NONE;
      endcase
   end

`ifndef SYNTHESIS
   // An accepted transaction always starts with the phase-to-radians product.
   a_start_x : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_LO && op_ff == OP_X))
      else $error("accepted transaction did not start the radians product");

   // The final sine product hands over to result delivery.
   a_sinx_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB && op_ff == OP_SINX) |=> (state_ff == ST_DONE))
      else $error("sine product did not lead to result delivery");

   // Horner term counters stay within their polynomial.
   a_term_range : assert property (@(posedge clock) disable iff (reset)
      !(op_ff == OP_COS && term_ff > COS_LAST) && !(op_ff == OP_SIN && term_ff > SIN_LAST))
      else $error("Horner term index out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/qnco_dpath.sv -----
// Datapath: phase accumulator, sample counter, shared multiplier, Horner registers and output.
`default_nettype none

module qnco_dpath
   import qnco_pkg::*;
#(
   parameter int PHASE_BITS = QNCO_PHASE_BITS,
   parameter int COUNT_BITS = QNCO_COUNT_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire qnco_cmd_type          cmd,
   output qnco_status_type            status,
   input  wire logic                  req_restart,
   input  wire logic [PHASE_BITS-1:0] phase_step,
   input  wire logic [15:0]           table_length,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [47:0]                rsp_tdata,
   output logic                       rsp_tlast
);

   localparam logic [PHASE_BITS-1:0] PHASE_RESET = {1'b1, {(PHASE_BITS-1){1'b0}}};
   localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   // Phase and count state.
   logic [PHASE_BITS-1:0] phase_ff, phase_in, phase_cur;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_cur;

   // Per-item registers.
   logic [30:0] r_ff;
   logic        odd_ff, neg_ff, last_ff;
   logic [15:0] idx_ff;

   // Folding of the current phase.
   logic [15:0] len_m1;
   logic        item_last;
   logic [31:0] p_word;
   logic [32:0] a_word;

   // Multiplier and working values.
   logic [MAG_W-1:0]        ua, ub;
   logic [HALF_W-1:0]       mul_b;
   logic [MAG_W+HALF_W-1:0] mprod;
   logic                    prod_neg, rnd_q31;
   logic [PROD_W-1:0]       prod_ff, prod_in, rnd, shifted;
   logic signed [VAL_W-1:0] mres, wb_val;
   logic signed [VAL_W-1:0] x_ff, x_in, z_ff, z_in, acc_ff, acc_in, c_ff, c_in;
   logic                    wb;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   // Current phase after an optional restart, then its fold into [0, pi].
   always_comb begin
      phase_cur = req_restart ? PHASE_RESET : phase_ff;
      count_cur = req_restart ? '0 : count_ff;
      len_m1    = (table_length == 16'd0) ? 16'd0 : (table_length - 16'd1);
      item_last = (CMP_W'(count_cur) == CMP_W'(len_m1));
      p_word    = 32'(phase_cur) << (32 - PHASE_BITS);
      a_word    = p_word[31] ? (33'h1_0000_0000 - {1'b0, p_word}) : {1'b0, p_word};
      phase_in  = item_last ? PHASE_RESET : (phase_cur + phase_step);
      count_in  = item_last ? '0 : (count_cur + COUNT_BITS'(1));
   end

   // Phase accumulator and sample counter advance once per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_RESET;
         count_ff <= '0;
      end else if (cmd.load_item) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // Capture the folded phase and the sample position of the transaction.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         r_ff    <= a_word[30:0];
         odd_ff  <= a_word[31];
         neg_ff  <= p_word[31];
         idx_ff  <= 16'(count_cur);
         last_ff <= item_last;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      ua       = '0;
      ub       = '0;
      prod_neg = 1'b0;
      rnd_q31  = 1'b0;
      case (cmd.op)
         OP_X: begin
            ua      = PI_Q30;
            ub      = MAG_W'(r_ff);
            rnd_q31 = 1'b1;
         end
         OP_Z: begin
            ua = mag_sat(x_ff);
            ub = mag_sat(x_ff);
         end
         OP_COS, OP_SIN: begin
            ua       = mag_sat(z_ff);
            ub       = mag_sat(acc_ff);
            prod_neg = z_ff[VAL_W-1] ^ acc_ff[VAL_W-1];
         end
         OP_SINX: begin
            ua       = mag_sat(x_ff);
            ub       = mag_sat(acc_ff);
            prod_neg = x_ff[VAL_W-1] ^ acc_ff[VAL_W-1];
         end
         default: prod_neg = 1'b0;
      endcase
   end

   // One 40x20 multiplier: low half of the second operand, then the high half.
   always_comb begin
      mul_b = (cmd.phase == MPH_HI) ? ub[MAG_W-1:HALF_W] : ub[HALF_W-1:0];
      mprod = ua * mul_b;
      case (cmd.phase)
         MPH_LO:  prod_in = PROD_W'(mprod);
         MPH_HI:  prod_in = prod_ff + {mprod, {HALF_W{1'b0}}};
         default: prod_in = prod_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Write back: round, apply the sign, add the next Horner constant.
   always_comb begin
      wb      = (cmd.phase == MPH_WB);
      rnd     = prod_ff + (rnd_q31 ? ROUND_Q31 : ROUND_Q30);
      shifted = rnd_q31 ? (rnd >> 31) : (rnd >> 30);
      mres    = signed'(shifted[VAL_W-1:0]);
      wb_val  = (prod_neg ? -mres : mres) + coef_addend(cmd.op, cmd.term);
      x_in    = x_ff;
      z_in    = z_ff;
      acc_in  = acc_ff;
      c_in    = c_ff;
      if (wb) begin
         case (cmd.op)
            OP_X: x_in = wb_val;
            OP_Z: begin
               z_in   = wb_val;
               acc_in = COS_COEF[0];
            end
            OP_COS: begin
               if (cmd.term == COS_LAST) begin
                  c_in   = wb_val;
                  acc_in = SIN_COEF[0];
               end else begin
                  acc_in = wb_val;
               end
            end
            OP_SIN, OP_SINX: acc_in = wb_val;
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      z_ff   <= z_in;
      acc_ff <= acc_in;
      c_ff   <= c_in;
   end

   // Output register holds a finished result until the transaction completes.
   always_comb begin
      status.out_ready = !rsp_valid_ff || rsp_tready;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      rsp_last_in      = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {idx_ff, to_q14(acc_ff, neg_ff ^ odd_ff), to_q14(c_ff, odd_ff)};
         rsp_last_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // A new result is never loaded over one that is still waiting.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_ready)
      else $error("result register overwritten while stalled");

   // The phase in radians never exceeds pi.
   a_x_range : assert property (@(posedge clock) disable iff (reset)
      (cmd.phase == MPH_WB && cmd.op == OP_X) |=>
      (!x_ff[VAL_W-1] && x_ff[MAG_W-1:0] <= PI_Q30))
      else $error("folded phase exceeds pi");

   // The last sample of a table restarts phase and count.
   a_table_wrap : assert property (@(posedge clock) disable iff (reset)
      (cmd.load_item && item_last) |=> (phase_ff == PHASE_RESET && count_ff == '0))
      else $error("table end did not restart phase and count");
`endif

endmodule

`default_nettype wire

// ----- rtl/quadrature_nco_table_generator.sv -----
// Top level of the quadrature NCO table generator: register file and core instances.
//
//   Channel  Direction  Handshake            Contents
//   req_     in         tvalid/tready        tdata[0] restart
//   rsp_     out        tvalid/tready/tlast  tdata cos_value, sin_value, sample_index; tlast last
//   csr_     in/out     APB psel/penable     phase_step at 0x0, table_length at 0x4
//
// Each sample takes fifteen products on one shared 40x20 multiplier, each in a low
// half, a high half and a round and write back, then a load of the result register.
// A new request is accepted only after the last one has loaded its result. Reset is
// synchronous: phase goes to -pi, the count to zero, phase_step to 0 and table_length
// to 1. A stalled result holds in its output register while the next request is
// worked on; delivery waits for it to drain.
`default_nettype none

module quadrature_nco_table_generator
   import qnco_pkg::*;
#(
   parameter int PHASE_BITS = QNCO_PHASE_BITS,
   parameter int COUNT_BITS = QNCO_COUNT_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [0] restart, [7:1] zero
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [47:0]                rsp_tdata,   // [15:0] cos_value, [31:16] sin_value,
                                                   // [47:32] sample_index
   output logic                       rsp_tlast,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [31:0]     phase_step_ff;
   logic [15:0]     table_length_ff;
   logic            csr_write;
   qnco_cmd_type    cmd;
   qnco_status_type status;

   // Register writes complete in the access cycle of a write transaction.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= 32'd0;
         table_length_ff <= 16'd1;
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_IDX_PHASE_STEP) begin
            phase_step_ff <= csr_pwdata;
         end else begin
            table_length_ff <= csr_pwdata[15:0];
         end
      end
   end

   // Register read back.
   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_TABLE_LENGTH: csr_prdata = {16'd0, table_length_ff};
         default:              csr_prdata = phase_step_ff;
      endcase
   end

   qnco_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   qnco_dpath #(
      .PHASE_BITS (PHASE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_restart  (req_tdata[0]),
      .phase_step   (phase_step_ff[31 -: PHASE_BITS]),
      .table_length (table_length_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire
